FILE: sv/fpbc_pkg.sv
package fpbc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int NUM_AXES    = 3;
  localparam int LANE_W      = 16;
  localparam int AXIS_W      = NUM_AXES * LANE_W;
  localparam int PLANE_W     = 4 * LANE_W;
  localparam int REG_ADDR_W  = 6;
  localparam int REG_IDX_LSB = 3;
  localparam int REG_IDX_W   = REG_ADDR_W - REG_IDX_LSB;
  localparam int CELL_STAGES = 4;
  // q1.14 normal against q8.8 coordinate: shift d up to the same scale
  localparam int FRAC_SHIFT  = 14;
  localparam int DSH_W       = LANE_W + FRAC_SHIFT;
  localparam int DOT_W       = 2 * LANE_W;
  localparam int DOTS_W      = DOT_W + 2;
  localparam int ABS_W       = DOT_W;
  localparam int TERM_W      = ABS_W + LANE_W;
  localparam int RAD_W       = TERM_W + 2;

  typedef enum logic {
    OP_POINT = 1'b0,
    OP_BOX   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    POS_FRONT    = 2'd0,
    POS_BACK     = 2'd1,
    POS_ONPLANE  = 2'd2,
    POS_SPANNING = 2'd3
  } pos_e;

  // request status that travels down the chain with the data
  typedef struct packed {
    logic vld;
    op_e  op;
    logic done;
    pos_e pos;
  } stat_t;

endpackage

FILE: sv/frustum_point_box_classifier_core.sv
// classifies a point or an oriented box against six frustum planes (left,
// right, top, bottom, near, far); a request is taken on every cycle that
// start is high, busy is tied low, and the result shows on position_o with
// done_o high for one cycle once it has passed the whole chain: six plane
// cells of four register stages each (products, sums, extent scaling,
// compare) sit in a chain, and throughput is one request per clock;
// the receiver must take every result in the cycle it appears
module frustum_point_box_classifier_core import fpbc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      operation_i,
  input  logic signed [COORD_WIDTH-1:0] center_x_i,
  input  logic signed [COORD_WIDTH-1:0] center_y_i,
  input  logic signed [COORD_WIDTH-1:0] center_z_i,
  input  logic [AXIS_W-1:0]         axis_first_i,
  input  logic [AXIS_W-1:0]         axis_second_i,
  input  logic [AXIS_W-1:0]         axis_third_i,
  input  logic [LANE_W-1:0]         extent_first_i,
  input  logic [LANE_W-1:0]         extent_second_i,
  input  logic [LANE_W-1:0]         extent_third_i,
  // result channel
  output logic                      done_o,
  output logic [1:0]                position_o,
  // plane register port, one 64-bit register every 8 bytes
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [REG_ADDR_W-1:0]     paddr,
  input  logic [PLANE_W-1:0]        pwdata,
  output logic [PLANE_W-1:0]        prdata,
  output logic                      pready
);

  localparam int LATENCY = NUM_PLANES * CELL_STAGES;

  // chain links, index 0 is the entry and NUM_PLANES the exit
  stat_t                            stat_c [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0]    cx_c   [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0]    cy_c   [NUM_PLANES+1];
  logic signed [COORD_WIDTH-1:0]    cz_c   [NUM_PLANES+1];
  logic [NUM_AXES-1:0][AXIS_W-1:0]  axes_c [NUM_PLANES+1];
  logic [NUM_AXES-1:0][LANE_W-1:0]  ext_c  [NUM_PLANES+1];

  logic [PLANE_W-1:0]               plane  [NUM_PLANES];
  logic [REG_IDX_W-1:0]             reg_idx;
  logic                             cfg_wr;

  // no stall anywhere in the chain
  assign busy   = 1'b0;
  assign pready = 1'b1;

  // entry: a point starts as back and a box as front until a plane decides
  always_comb begin
    stat_c[0].vld  = start && !busy;
    stat_c[0].op   = op_e'(operation_i);
    stat_c[0].done = 1'b0;
    stat_c[0].pos  = (op_e'(operation_i) == OP_BOX) ? POS_FRONT : POS_BACK;
  end

  assign cx_c[0]   = center_x_i;
  assign cy_c[0]   = center_y_i;
  assign cz_c[0]   = center_z_i;
  assign axes_c[0] = {axis_third_i, axis_second_i, axis_first_i};
  assign ext_c[0]  = {extent_third_i, extent_second_i, extent_first_i};

  // register access decode, byte lanes below the index are ignored
  assign reg_idx = paddr[REG_ADDR_W-1:REG_IDX_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (32'(reg_idx) < NUM_PLANES) begin
      prdata = plane[reg_idx];
    end
  end

  // one cell per plane, in left..far order
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fpbc_cell #(
      .COORD_WIDTH (COORD_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_we_i    (cfg_wr && (32'(reg_idx) == i)),
      .cfg_wdata_i (pwdata),
      .plane_o     (plane[i]),
      .stat_i      (stat_c[i]),
      .cx_i        (cx_c[i]),
      .cy_i        (cy_c[i]),
      .cz_i        (cz_c[i]),
      .axes_i      (axes_c[i]),
      .ext_i       (ext_c[i]),
      .stat_o      (stat_c[i+1]),
      .cx_o        (cx_c[i+1]),
      .cy_o        (cy_c[i+1]),
      .cz_o        (cz_c[i+1]),
      .axes_o      (axes_c[i+1]),
      .ext_o       (ext_c[i+1])
    );
  end

  // exit: the last cell's status register drives the result directly
  assign done_o     = stat_c[NUM_PLANES].vld;
  assign position_o = stat_c[NUM_PLANES].pos;

`ifndef SYNTHESIS
  // every result comes from a request taken a fixed latency earlier
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, LATENCY))
    else $error("result without matching request");

  // a point never spans a plane
  a_point_no_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(operation_i, LATENCY) == OP_POINT)) |-> (position_o != POS_SPANNING))
    else $error("point classified as spanning");

  // a box is never reported on a plane
  a_box_no_onplane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ($past(operation_i, LATENCY) == OP_BOX)) |-> (position_o != POS_ONPLANE))
    else $error("box classified as on plane");
`endif

endmodule

FILE: sv/fpbc_cell.sv
module fpbc_cell import fpbc_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [PLANE_W-1:0]                   cfg_wdata_i,
  output logic [PLANE_W-1:0]                   plane_o,
  input  stat_t                                stat_i,
  input  logic signed [COORD_WIDTH-1:0]        cx_i,
  input  logic signed [COORD_WIDTH-1:0]        cy_i,
  input  logic signed [COORD_WIDTH-1:0]        cz_i,
  input  logic [NUM_AXES-1:0][AXIS_W-1:0]      axes_i,
  input  logic [NUM_AXES-1:0][LANE_W-1:0]      ext_i,
  output stat_t                                stat_o,
  output logic signed [COORD_WIDTH-1:0]        cx_o,
  output logic signed [COORD_WIDTH-1:0]        cy_o,
  output logic signed [COORD_WIDTH-1:0]        cz_o,
  output logic [NUM_AXES-1:0][AXIS_W-1:0]      axes_o,
  output logic [NUM_AXES-1:0][LANE_W-1:0]      ext_o
);

  localparam int PW  = COORD_WIDTH + LANE_W;
  localparam int DW  = ((PW > DSH_W) ? PW : DSH_W) + 2;
  localparam int CPW = DW + FRAC_SHIFT;
  localparam int KW  = (CPW > RAD_W + 1) ? CPW : RAD_W + 1;

  logic [PLANE_W-1:0] plane_q;

  // payload delay line, one entry per stage
  stat_t                              stat_q [CELL_STAGES];
  logic signed [COORD_WIDTH-1:0]      cx_q   [CELL_STAGES];
  logic signed [COORD_WIDTH-1:0]      cy_q   [CELL_STAGES];
  logic signed [COORD_WIDTH-1:0]      cz_q   [CELL_STAGES];
  logic [NUM_AXES-1:0][AXIS_W-1:0]    axes_q [CELL_STAGES];
  logic [NUM_AXES-1:0][LANE_W-1:0]    ext_q  [CELL_STAGES];

  logic signed [LANE_W-1:0]      nrm [NUM_AXES];
  logic signed [LANE_W-1:0]      dcoef;
  logic signed [COORD_WIDTH-1:0] crd [NUM_AXES];

  logic signed [PW-1:0]     pd1_d [NUM_AXES];
  logic signed [PW-1:0]     pd1_q [NUM_AXES];
  logic signed [DOT_W-1:0]  dp1_d [NUM_AXES][NUM_AXES];
  logic signed [DOT_W-1:0]  dp1_q [NUM_AXES][NUM_AXES];

  logic signed [DW-1:0]     dist2_d, dist2_q, dist3_q;
  logic signed [DOTS_W-1:0] dsum  [NUM_AXES];
  logic [ABS_W-1:0]         dabs2_d [NUM_AXES];
  logic [ABS_W-1:0]         dabs2_q [NUM_AXES];

  logic [TERM_W-1:0]        term3_d [NUM_AXES];
  logic [TERM_W-1:0]        term3_q [NUM_AXES];

  logic [RAD_W-1:0]         rad;
  logic signed [KW-1:0]     cdist;
  logic signed [KW-1:0]     rk;
  stat_t                    stat4_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q <= '0;
    end else if (cfg_we_i) begin
      plane_q <= cfg_wdata_i;
    end
  end

  assign plane_o = plane_q;

  // stage 1: all products
  always_comb begin
    crd[0] = cx_i;
    crd[1] = cy_i;
    crd[2] = cz_i;
    dcoef  = signed'(plane_q[NUM_AXES*LANE_W +: LANE_W]);
    for (int j = 0; j < NUM_AXES; j++) begin
      nrm[j]   = signed'(plane_q[j*LANE_W +: LANE_W]);
      pd1_d[j] = nrm[j] * crd[j];
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int j = 0; j < NUM_AXES; j++) begin
        dp1_d[k][j] = nrm[j] * signed'(axes_i[k][j*LANE_W +: LANE_W]);
      end
    end
  end

  // stage 2: center distance and absolute dot products
  always_comb begin
    dist2_d = DW'(pd1_q[0]) + DW'(pd1_q[1]) + DW'(pd1_q[2])
            + (DW'(dcoef) <<< FRAC_SHIFT);
    for (int k = 0; k < NUM_AXES; k++) begin
      dsum[k]    = DOTS_W'(dp1_q[k][0]) + DOTS_W'(dp1_q[k][1]) + DOTS_W'(dp1_q[k][2]);
      dabs2_d[k] = (dsum[k] < 0) ? ABS_W'(-dsum[k]) : ABS_W'(dsum[k]);
    end
  end

  // stage 3: scale by half extents
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      term3_d[k] = TERM_W'(dabs2_q[k]) * TERM_W'(ext_q[1][k]);
    end
  end

  // stage 4: radius, compare and merge with earlier planes
  always_comb begin
    rad     = RAD_W'(term3_q[0]) + RAD_W'(term3_q[1]) + RAD_W'(term3_q[2]);
    cdist   = KW'(dist3_q) <<< FRAC_SHIFT;
    rk      = signed'(KW'(rad));
    stat4_d = stat_q[2];
    if (stat_q[2].vld && !stat_q[2].done) begin
      unique case (stat_q[2].op)
        OP_POINT: begin
          if (dist3_q == '0) begin
            stat4_d.done = 1'b1;
            stat4_d.pos  = POS_ONPLANE;
          end else if (dist3_q < 0) begin
            stat4_d.done = 1'b1;
            stat4_d.pos  = POS_FRONT;
          end
        end
        OP_BOX: begin
          if (cdist > 0) begin
            if (cdist < rk) begin
              stat4_d.done = 1'b1;
              stat4_d.pos  = POS_SPANNING;
            end
          end else if (cdist < 0) begin
            stat4_d.done = 1'b1;
            stat4_d.pos  = (cdist > -rk) ? POS_SPANNING : POS_BACK;
          end
        end
        default: stat4_d = stat_q[2];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < CELL_STAGES; s++) begin
        stat_q[s] <= '0;
      end
    end else begin
      stat_q[0] <= stat_i;
      stat_q[1] <= stat_q[0];
      stat_q[2] <= stat_q[1];
      stat_q[3] <= stat4_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q[0]   <= cx_i;
    cy_q[0]   <= cy_i;
    cz_q[0]   <= cz_i;
    axes_q[0] <= axes_i;
    ext_q[0]  <= ext_i;
    for (int s = 1; s < CELL_STAGES; s++) begin
      cx_q[s]   <= cx_q[s-1];
      cy_q[s]   <= cy_q[s-1];
      cz_q[s]   <= cz_q[s-1];
      axes_q[s] <= axes_q[s-1];
      ext_q[s]  <= ext_q[s-1];
    end
    pd1_q   <= pd1_d;
    dp1_q   <= dp1_d;
    dist2_q <= dist2_d;
    dabs2_q <= dabs2_d;
    dist3_q <= dist2_q;
    term3_q <= term3_d;
  end

  assign stat_o = stat_q[CELL_STAGES-1];
  assign cx_o   = cx_q[CELL_STAGES-1];
  assign cy_o   = cy_q[CELL_STAGES-1];
  assign cz_o   = cz_q[CELL_STAGES-1];
  assign axes_o = axes_q[CELL_STAGES-1];
  assign ext_o  = ext_q[CELL_STAGES-1];

endmodule
